@@ rtl/core/ffrx_pkg.sv @@
// Package for the fixed-frame receiver with XOR check.
// Holds frame constants, result status codes and the memory request type.
// No dependencies.
package ffrx_pkg;

  localparam int unsigned FRAME_LEN_DEF = 39;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned BYTE_W        = 8;

  localparam logic [BYTE_W-1:0] HDR0 = 8'h01;
  localparam logic [BYTE_W-1:0] HDR1 = 8'h55;
  localparam logic [BYTE_W-1:0] TL0  = 8'h41;
  localparam logic [BYTE_W-1:0] TL1  = 8'h42;
  localparam logic [BYTE_W-1:0] TL2  = 8'h43;
  localparam logic [BYTE_W-1:0] TL3  = 8'h44;

  // Header and tail bytes folded into the check value
  localparam logic [BYTE_W-1:0] CHK_SEED = HDR0 ^ HDR1 ^ TL0 ^ TL1 ^ TL2 ^ TL3;

  localparam logic [IDX_W-1:0] SKIP_POS  = 6'd18;
  localparam logic [IDX_W-1:0] CHECK_POS = 6'd33;

  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_HDR_ERR = 2'd1;
  localparam logic [1:0] ST_TL_ERR  = 2'd2;
  localparam logic [1:0] ST_CHK_ERR = 2'd3;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

@@ rtl/core/ffrx_store.sv @@
// Frame byte store: one write port, one read port with registered read data.
// Depends on ffrx_pkg for the request type and widths.
module ffrx_store #(
  parameter int unsigned DEPTH = ffrx_pkg::FRAME_LEN_DEF
) (
  input  logic                          clk_i,
  input  ffrx_pkg::mem_req_t            req_i,
  output logic [ffrx_pkg::BYTE_W-1:0]   rd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [ffrx_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [ffrx_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/ffrx_ctrl.sv @@
// Receive, check and readout sequencer with the result output register.
// Depends on ffrx_pkg; drives the frame store through a mem_req_t.
module ffrx_ctrl #(
  parameter int unsigned FRAME_LEN = ffrx_pkg::FRAME_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [ffrx_pkg::BYTE_W-1:0]   rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ffrx_pkg::BYTE_W-1:0]   data_byte_o,
  output logic [ffrx_pkg::IDX_W-1:0]    byte_index_o,
  output logic                          last_o,
  output logic                          link_restored_o,
  output ffrx_pkg::mem_req_t            mem_req_o,
  input  logic [ffrx_pkg::BYTE_W-1:0]   mem_rd_data_i
);

  localparam int unsigned IW = ffrx_pkg::IDX_W;
  localparam int unsigned CW = IW + 1;

  localparam logic [IW-1:0] LAST_POS = IW'(FRAME_LEN - 1);
  localparam logic [IW-1:0] TL0_POS  = IW'(FRAME_LEN - 4);
  localparam logic [IW-1:0] TL1_POS  = IW'(FRAME_LEN - 3);
  localparam logic [IW-1:0] TL2_POS  = IW'(FRAME_LEN - 2);
  localparam logic [CW-1:0] LEN_CNT  = CW'(FRAME_LEN);

  localparam logic [1:0] S_RECV   = 2'd0;
  localparam logic [1:0] S_CHK_RD = 2'd1;
  localparam logic [1:0] S_CHK    = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [IW-1:0]               pos_q, pos_d;
  logic [ffrx_pkg::BYTE_W-1:0] acc_q, acc_d;
  logic                        link_down_q, link_down_d;
  logic [CW-1:0]               issue_idx_q, issue_idx_d;
  logic [IW-1:0]               out_idx_q, out_idx_d;
  logic                        rd_pend_q, rd_pend_d;

  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  status_q, status_d;
  logic [ffrx_pkg::BYTE_W-1:0] data_q, data_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic                        last_q, last_d;
  logic                        lr_q, lr_d;

  logic out_free, accept, hdr_err, tl_err, in_check, chk_ok, load_rd, issue_rd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign rx_ready_o = (state_q == S_RECV) && out_free;
  assign accept     = rx_valid_i && rx_ready_o;

  assign hdr_err = ((pos_q == '0) && (rx_byte_i != ffrx_pkg::HDR0)) ||
                   ((pos_q == IW'(1)) && (rx_byte_i != ffrx_pkg::HDR1));
  assign tl_err  = ((pos_q == TL0_POS)  && (rx_byte_i != ffrx_pkg::TL0)) ||
                   ((pos_q == TL1_POS)  && (rx_byte_i != ffrx_pkg::TL1)) ||
                   ((pos_q == TL2_POS)  && (rx_byte_i != ffrx_pkg::TL2)) ||
                   ((pos_q == LAST_POS) && (rx_byte_i != ffrx_pkg::TL3));
  assign in_check = (pos_q >= IW'(2)) && (pos_q < TL0_POS) &&
                    (pos_q != ffrx_pkg::SKIP_POS) && (pos_q != ffrx_pkg::CHECK_POS);
  assign chk_ok   = (mem_rd_data_i == (acc_q ^ ffrx_pkg::CHK_SEED));

  // Readout pipeline: one read in flight, load it when the output slot frees
  assign load_rd  = (state_q == S_READ) && rd_pend_q && out_free;
  assign issue_rd = (state_q == S_READ) && (issue_idx_q < LEN_CNT) &&
                    (!rd_pend_q || load_rd);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    link_down_d = link_down_q;
    issue_idx_d = issue_idx_q;
    out_idx_d   = out_idx_q;
    rd_pend_d   = rd_pend_q;

    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    data_d      = data_q;
    idx_d       = idx_q;
    last_d      = last_q;
    lr_d        = lr_q;

    mem_req_o       = '0;
    mem_req_o.waddr = pos_q;
    mem_req_o.wdata = rx_byte_i;
    mem_req_o.raddr = issue_idx_q[IW-1:0];

    case (state_q)
      S_RECV: begin
        if (accept) begin
          if (hdr_err || tl_err) begin
            out_valid_d = 1'b1;
            status_d    = hdr_err ? ffrx_pkg::ST_HDR_ERR : ffrx_pkg::ST_TL_ERR;
            data_d      = '0;
            idx_d       = pos_q;
            last_d      = 1'b1;
            lr_d        = 1'b0;
            pos_d       = '0;
            acc_d       = '0;
            link_down_d = 1'b1;
          end else begin
            mem_req_o.we = 1'b1;
            if (in_check) begin
              acc_d = acc_q ^ rx_byte_i;
            end
            if (pos_q == LAST_POS) begin
              pos_d   = '0;
              state_d = S_CHK_RD;
            end else begin
              pos_d = pos_q + IW'(1);
            end
          end
        end
      end
      S_CHK_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = ffrx_pkg::CHECK_POS;
        state_d         = S_CHK;
      end
      S_CHK: begin
        if (chk_ok) begin
          acc_d       = '0;
          issue_idx_d = '0;
          out_idx_d   = '0;
          rd_pend_d   = 1'b0;
          state_d     = S_READ;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ffrx_pkg::ST_CHK_ERR;
          data_d      = '0;
          idx_d       = ffrx_pkg::CHECK_POS;
          last_d      = 1'b1;
          lr_d        = 1'b0;
          acc_d       = '0;
          link_down_d = 1'b1;
          state_d     = S_RECV;
        end
      end
      S_READ: begin
        if (issue_rd) begin
          mem_req_o.re = 1'b1;
          issue_idx_d  = issue_idx_q + CW'(1);
        end
        rd_pend_d = issue_rd || (rd_pend_q && !load_rd);
        if (load_rd) begin
          out_valid_d = 1'b1;
          status_d    = ffrx_pkg::ST_DATA;
          data_d      = mem_rd_data_i;
          idx_d       = out_idx_q;
          last_d      = (out_idx_q == LAST_POS);
          lr_d        = link_down_q;
          out_idx_d   = out_idx_q + IW'(1);
          if (out_idx_q == LAST_POS) begin
            link_down_d = 1'b0;
            state_d     = S_RECV;
          end
        end
      end
      default: begin
        state_d = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RECV;
      pos_q       <= '0;
      acc_q       <= '0;
      link_down_q <= 1'b1;
      issue_idx_q <= '0;
      out_idx_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      link_down_q <= link_down_d;
      issue_idx_q <= issue_idx_d;
      out_idx_q   <= out_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    idx_q    <= idx_d;
    last_q   <= last_d;
    lr_q     <= lr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign data_byte_o     = data_q;
  assign byte_index_o    = idx_q;
  assign last_o          = last_q;
  assign link_restored_o = lr_q;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS)
    else $error("frame position out of range");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != ffrx_pkg::ST_DATA) |-> last_q && (data_q == '0) && !lr_q)
    else $error("error result with bad fields");

  a_read_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) && rd_pend_q |-> issue_idx_q == ({1'b0, out_idx_q} + CW'(1)))
    else $error("readout pipeline out of step");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rd && (out_idx_q == LAST_POS) |=> (state_q == S_RECV) && !link_down_q && (pos_q == '0))
    else $error("frame readout did not finish cleanly");
`endif

endmodule

@@ rtl/core/fixed_frame_receiver_xor_check_unit.sv @@
// Fixed-frame serial receiver with XOR check: top level.
// Usage:
//   rx channel (rx_valid_i/rx_ready_o/rx_byte_i) takes one received byte a beat.
//   out channel (out_valid_o/out_ready_i) gives results: status, data byte,
//   byte index, last mark and link-restored flag.
// Frames are FRAME_LEN bytes: 0x01 0x55 header, 0x41..0x44 tail, check at 33.
// A byte that completes no frame gives no result.
// A header or tail error gives one result, loaded into the output register
// at the edge the byte is taken.
// After the last tail byte, the check byte is read back from the frame store;
// a mismatch gives one error beat, a match streams FRAME_LEN data beats at one
// per cycle unless the output stalls, paced by the single read port of the store.
// The rx side is held off from the final byte until the last beat of the
// readout is loaded.
// A stalled receiver holds the output register and, behind it, the readout.
// Reset clears position and check, sets the link-down flag and empties the
// output register; the frame store needs no clearing.
// Depends on ffrx_pkg, ffrx_store and ffrx_ctrl.
module fixed_frame_receiver_xor_check_unit #(
  parameter int unsigned FRAME_LEN = ffrx_pkg::FRAME_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [ffrx_pkg::BYTE_W-1:0]   rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ffrx_pkg::BYTE_W-1:0]   data_byte_o,
  output logic [ffrx_pkg::IDX_W-1:0]    byte_index_o,
  output logic                          last_o,
  output logic                          link_restored_o
);

  ffrx_pkg::mem_req_t          mem_req;
  logic [ffrx_pkg::BYTE_W-1:0] mem_rd_data;

  ffrx_store #(
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  ffrx_ctrl #(
    .FRAME_LEN (FRAME_LEN)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .last_o          (last_o),
    .link_restored_o (link_restored_o),
    .mem_req_o       (mem_req),
    .mem_rd_data_i   (mem_rd_data)
  );

endmodule
